>>> design/cd_audio_play_controller_assert.svh
// Assertion macros used by the checker file of the audio play controller.
`ifndef CD_AUDIO_PLAY_CONTROLLER_ASSERT_SVH
`define CD_AUDIO_PLAY_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDAP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cdap assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CDAP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cdap assertion failed");

`endif

>>> design/cdap_pkg.sv
// Types, codes and address helper functions of the audio play controller.
package cdap_pkg;

   localparam int MaxTracks = 99;
   localparam int TocAddrW  = $clog2(MaxTracks);
   localparam int TocDataW  = 28;

   typedef enum logic [1:0] {
      PLAY_ACTIVE = 2'd0,
      PLAY_PAUSED = 2'd1,
      PLAY_DONE   = 2'd2,
      PLAY_IDLE   = 2'd3
   } play_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_LOOK_A,
      SEQ_LOOK_B,
      SEQ_LOOK_C,
      SEQ_EXEC,
      SEQ_WALK,
      SEQ_DONE
   } seq_state_type;

   localparam logic [1:0] OPER_CMD    = 2'd0;
   localparam logic [1:0] OPER_TICK   = 2'd1;
   localparam logic [1:0] OPER_STATUS = 2'd2;
   localparam logic [1:0] OPER_TOC    = 2'd3;

   localparam logic [1:0] CSR_TRACK_COUNT = 2'd0;
   localparam logic [1:0] CSR_LEADOUT     = 2'd1;
   localparam logic [1:0] CSR_TOC_VALID   = 2'd2;

   localparam logic [7:0] OPC_TEST_READY  = 8'h00;
   localparam logic [7:0] OPC_REZERO      = 8'h01;
   localparam logic [7:0] OPC_SEEK        = 8'h0B;
   localparam logic [7:0] OPC_MODE_SELECT = 8'h15;
   localparam logic [7:0] OPC_SEEK_10     = 8'h2B;
   localparam logic [7:0] OPC_PLAY_10     = 8'h45;
   localparam logic [7:0] OPC_PLAY_MSF    = 8'h47;
   localparam logic [7:0] OPC_PLAY_TRACK  = 8'h48;
   localparam logic [7:0] OPC_PAUSE       = 8'h4B;
   localparam logic [7:0] OPC_STOP        = 8'h4E;
   localparam logic [7:0] OPC_PLAY_12     = 8'hA5;
   localparam logic [7:0] OPC_VND_PLAY    = 8'hC8;
   localparam logic [7:0] OPC_VND_START   = 8'hC9;
   localparam logic [7:0] OPC_VND_PAUSE   = 8'hCA;
   localparam logic [7:0] OPC_VND_STOP    = 8'hCB;
   localparam logic [7:0] OPC_VND_SCAN    = 8'hCD;

   localparam logic [1:0] FORM_LBA   = 2'd0;
   localparam logic [1:0] FORM_MSF   = 2'd1;
   localparam logic [1:0] FORM_TRACK = 2'd2;

   localparam logic [7:0]  NO_TOC_CONTROL = 8'h14;
   localparam logic [19:0] LBA_MAX        = 20'hFFFFF;

   function automatic logic [7:0] bcd_val(input logic [7:0] v);
      logic [7:0] r;
      r = {4'b0, v[7:4]} * 8'd10 + {4'b0, v[3:0]};
      return r;
   endfunction

   function automatic logic [19:0] msf_bcd(input logic [7:0] m, input logic [7:0] s,
                                           input logic [7:0] f);
      logic [19:0] r;
      r = {12'b0, bcd_val(m)} * 20'd4500 + {12'b0, bcd_val(s)} * 20'd75
          + {12'b0, bcd_val(f)};
      return r;
   endfunction

   // Standard MSF carries the two-second pregap, so addresses below it clamp to zero.
   function automatic logic [19:0] msf_std(input logic [7:0] m, input logic [7:0] s,
                                           input logic [7:0] f);
      logic [20:0] v;
      v = {13'b0, m} * 21'd4500 + {13'b0, s} * 21'd75 + {13'b0, f};
      return (v >= 21'd150) ? 20'(v - 21'd150) : 20'd0;
   endfunction

   function automatic logic [19:0] lba_field(input logic [31:0] mid);
      logic [19:0] r;
      r = ((mid[31:24] != 8'd0) || (mid[23:20] != 4'd0)) ? LBA_MAX : mid[19:0];
      return r;
   endfunction

endpackage

>>> design/cd_audio_play_controller.sv
// Audio play controller: takes one item at a time and steps it through lookups A, B and C,
// execute, a walk over the TOC entries (if a TOC is valid) through the single table RAM
// read port, and done. The next item is taken once the result is loaded into the output
// register, so a stalled result holds off the next load. Reset is synchronous: play state
// idle, addresses and counters zero, track count 1; the TOC RAM is not cleared.
module cd_audio_play_controller
   import cdap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_cmd_opcode,
   input  logic [7:0]  req_cmd_flags,
   input  logic [31:0] req_cmd_bytes_mid,
   input  logic [31:0] req_cmd_bytes_tail,
   input  logic [6:0]  req_toc_index,
   input  logic [19:0] req_toc_start_lba,
   input  logic [7:0]  req_toc_control,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_valid,
   output logic [19:0] rsp_frame_lba,
   output logic [1:0]  rsp_audio_status,
   output logic [6:0]  rsp_track_number,
   output logic [7:0]  rsp_track_control,
   output logic [19:0] rsp_abs_lba,
   output logic [19:0] rsp_rel_lba,
   output logic [7:0]  rsp_flush_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers.
   logic [6:0]  track_count_ff;
   logic [19:0] leadout_ff;
   logic        toc_valid_ff;

   // Latched item.
   logic [1:0]  oper_ff;
   logic [7:0]  opc_ff, flags_ff;
   logic [31:0] mid_ff, tail_ff;
   logic [6:0]  tidx_ff;
   logic [19:0] tstart_ff;
   logic [7:0]  tctrl_ff;

   // Play state.
   play_state_type play_ff, play_in;
   logic [19:0] cur_ff, cur_in, fetch_ff, fetch_in, stop_ff, stop_in;
   logic        scan_ff, scan_in, rev_ff, rev_in;
   logic [7:0]  flush_ff, flush_in;
   logic        fv_ff, fv_in;
   logic [19:0] flba_ff, flba_in;

   // Sequencer.
   seq_state_type seq_ff, seq_in;
   logic [19:0] trk_start_ff, trk_start_in, trk_next_ff, trk_next_in;
   logic [6:0]  walk_k_ff, walk_k_in, pend_k_ff;
   logic        pend_ff, pend_in;
   logic [19:0] hit_start_ff, hit_start_in;
   logic [6:0]  hit_trk_ff, hit_trk_in;
   logic [7:0]  hit_ctrl_ff, hit_ctrl_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in, rsp_load;
   logic        o_fv_ff;
   logic [19:0] o_flba_ff, o_abs_ff, o_rel_ff;
   logic [1:0]  o_status_ff;
   logic [6:0]  o_trk_ff;
   logic [7:0]  o_ctrl_ff, o_flush_ff;

   // TOC RAM.
   logic                ram_we;
   logic [TocAddrW-1:0] ram_raddr;
   logic [TocDataW-1:0] ram_rdata;

   logic        csr_wr;
   logic [6:0]  ntracks, walk_limit;
   logic [19:0] leadout_eff;
   logic [7:0]  c3, c4, c5, c6, c7, c8;
   logic [7:0]  bcd_t;
   logic [6:0]  trk, trk2, trk_idx, trk2_idx;
   logic        req_xfer, walk_issue;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         track_count_ff <= 7'd1;
         leadout_ff     <= 20'd0;
         toc_valid_ff   <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_TRACK_COUNT: track_count_ff <= csr_pwdata[6:0];
            CSR_LEADOUT:     leadout_ff     <= csr_pwdata[19:0];
            CSR_TOC_VALID:   toc_valid_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_TRACK_COUNT: csr_prdata = {25'd0, track_count_ff};
         CSR_LEADOUT:     csr_prdata = {12'd0, leadout_ff};
         CSR_TOC_VALID:   csr_prdata = {31'd0, toc_valid_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // Effective track count and lead-out.
   always_comb begin
      if (!toc_valid_ff || track_count_ff == 7'd0) begin
         ntracks = 7'd1;
      end else if (track_count_ff > 7'(MaxTracks)) begin
         ntracks = 7'(MaxTracks);
      end else begin
         ntracks = track_count_ff;
      end
      leadout_eff = toc_valid_ff ? leadout_ff : 20'd0;
      walk_limit  = toc_valid_ff ? ntracks : 7'd0;
   end

   assign c3 = mid_ff[23:16];
   assign c4 = mid_ff[15:8];
   assign c5 = mid_ff[7:0];
   assign c6 = tail_ff[31:24];
   assign c7 = tail_ff[23:16];
   assign c8 = tail_ff[15:8];

   // Track pair for the track-form commands, clamped to the table.
   always_comb begin
      bcd_t = bcd_val(c5);
      if (opc_ff == OPC_PLAY_TRACK) begin
         trk  = (c4 <= 8'd99) ? 7'(c4 - 8'd1) : 7'd98;
         trk2 = (c7 < 8'd99) ? c7[6:0] : 7'd99;
      end else begin
         trk  = (bcd_t <= 8'd99) ? 7'(bcd_t - 8'd1) : 7'd98;
         trk2 = (bcd_t < 8'd99) ? bcd_t[6:0] : 7'd99;
      end
      trk_idx  = (trk < ntracks) ? trk : 7'(ntracks - 7'd1);
      trk2_idx = (trk2 < ntracks) ? trk2 : 7'(ntracks - 7'd1);
   end

   // Command, tick and TOC write semantics, applied in the execute step.
   always_comb begin
      logic [1:0]  form;
      logic [19:0] addr, nxt, e;
      logic [20:0] sum;
      logic        sr, fl, ff;
      play_in  = play_ff;
      cur_in   = cur_ff;
      fetch_in = fetch_ff;
      stop_in  = stop_ff;
      scan_in  = scan_ff;
      rev_in   = rev_ff;
      flush_in = flush_ff;
      fv_in    = 1'b0;
      flba_in  = 20'd0;
      ram_we   = 1'b0;
      form     = tail_ff[7:6];
      addr     = 20'd0;
      nxt      = 20'd0;
      e        = 20'd0;
      sr       = 1'b0;
      fl       = 1'b0;
      ff       = 1'b0;
      sum      = 21'd0;
      case (oper_ff)
         OPER_CMD: begin
            if (opc_ff != OPC_MODE_SELECT) begin
               if (opc_ff != OPC_VND_SCAN) begin
                  scan_in = 1'b0;
               end
               case (opc_ff)
                  OPC_VND_PAUSE: begin
                     if (flags_ff == 8'h10) begin
                        if (play_ff == PLAY_ACTIVE) play_in = PLAY_PAUSED;
                     end else if (play_ff == PLAY_PAUSED) begin
                        play_in = PLAY_ACTIVE;
                     end
                  end
                  OPC_VND_SCAN: begin
                     if (form == FORM_LBA) begin
                        addr = lba_field(mid_ff);
                     end else if (form == FORM_MSF) begin
                        addr = msf_std(c3, c4, c5);
                     end else begin
                        addr = cur_ff;
                     end
                     cur_in  = addr;
                     fl      = 1'b1;
                     scan_in = 1'b1;
                     rev_in  = flags_ff[4];
                     if (!flags_ff[4] && stop_ff <= addr) stop_in = leadout_eff;
                     play_in = PLAY_ACTIVE;
                  end
                  OPC_VND_PLAY, OPC_VND_START, OPC_VND_STOP: begin
                     if (form == FORM_TRACK && bcd_t == 8'd0) begin
                        if (opc_ff != OPC_VND_STOP) play_in = PLAY_IDLE;
                     end else begin
                        if (form == FORM_MSF) begin
                           addr = (opc_ff == OPC_VND_START) ? msf_bcd(c3, c4, c5)
                                                            : msf_bcd(c5, c6, c7);
                        end else if (form == FORM_TRACK) begin
                           addr = trk_start_ff;
                           nxt  = trk_next_ff;
                        end else begin
                           addr = lba_field(mid_ff);
                        end
                        if (opc_ff == OPC_VND_STOP) begin
                           e       = (form == FORM_TRACK) ? nxt : addr;
                           stop_in = e;
                           if ((play_ff == PLAY_ACTIVE || play_ff == PLAY_PAUSED)
                               && cur_ff >= e) begin
                              play_in = PLAY_IDLE;
                           end
                        end else if (opc_ff == OPC_VND_START) begin
                           if (flags_ff[4]) begin
                              stop_in = addr;
                              if (cur_ff < addr) play_in = PLAY_ACTIVE;
                           end else begin
                              cur_in  = addr;
                              fl      = 1'b1;
                              play_in = PLAY_ACTIVE;
                              if (form == FORM_TRACK || stop_ff <= addr) stop_in = leadout_eff;
                           end
                        end else begin
                           cur_in = addr;
                           fl     = 1'b1;
                           if (form == FORM_TRACK) begin
                              stop_in = nxt;
                           end else if (stop_ff <= addr) begin
                              stop_in = leadout_eff;
                           end
                           play_in = flags_ff[4] ? PLAY_ACTIVE : PLAY_PAUSED;
                        end
                     end
                  end
                  OPC_PLAY_MSF: begin
                     addr = (c3 == 8'hFF && c4 == 8'hFF && c5 == 8'hFF) ? cur_ff
                                                                       : msf_std(c3, c4, c5);
                     nxt  = msf_std(c6, c7, c8);
                     sr   = 1'b1;
                  end
                  OPC_PLAY_TRACK: begin
                     if (c4 == 8'd0) begin
                        play_in = PLAY_IDLE;
                     end else begin
                        addr = trk_start_ff;
                        nxt  = trk_next_ff;
                        sr   = 1'b1;
                     end
                  end
                  OPC_PLAY_10, OPC_PLAY_12: begin
                     ff   = (mid_ff == 32'hFFFFFFFF);
                     addr = ff ? cur_ff : lba_field(mid_ff);
                     if (opc_ff == OPC_PLAY_10) begin
                        nxt = addr + {4'd0, c7, c8};
                     end else begin
                        nxt = addr + tail_ff[19:0];
                     end
                     sr = 1'b1;
                  end
                  OPC_PAUSE: begin
                     if (c8[0]) begin
                        if (play_ff == PLAY_PAUSED) play_in = PLAY_ACTIVE;
                     end else if (play_ff == PLAY_ACTIVE) begin
                        play_in = PLAY_PAUSED;
                     end
                  end
                  OPC_STOP, OPC_REZERO, OPC_SEEK, OPC_SEEK_10: begin
                     play_in = PLAY_IDLE;
                  end
                  default: ;
               endcase
               if (sr) begin
                  cur_in = addr;
                  fl     = 1'b1;
                  if (addr != nxt) begin
                     stop_in = nxt;
                     play_in = (addr < nxt) ? PLAY_ACTIVE : PLAY_IDLE;
                  end
               end
               if (fl) begin
                  fetch_in = cur_in;
                  flush_in = flush_ff + 8'd1;
               end
            end
         end
         OPER_TICK: begin
            if (play_ff == PLAY_ACTIVE && toc_valid_ff && fetch_ff < stop_ff) begin
               fv_in    = 1'b1;
               flba_in  = fetch_ff;
               fetch_in = fetch_ff + 20'd1;
               sum      = {1'b0, cur_ff} + (scan_ff ? 21'd8 : 21'd1);
               if (scan_ff && rev_ff) begin
                  cur_in = (cur_ff > 20'd8) ? cur_ff - 20'd8 : 20'd0;
               end else if (sum >= {1'b0, stop_ff}) begin
                  cur_in  = stop_ff;
                  play_in = PLAY_DONE;
                  scan_in = 1'b0;
               end else begin
                  cur_in = sum[19:0];
               end
            end
         end
         OPER_TOC: begin
            if (tidx_ff < 7'(MaxTracks)) begin
               ram_we  = 1'b1;
               play_in = PLAY_IDLE;
               scan_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign req_xfer   = req_valid & ~req_stall;
   assign walk_issue = (walk_k_ff < walk_limit);

   // Sequencer: two table lookups, execute, then one TOC entry per cycle.
   always_comb begin
      logic [19:0] st;
      seq_in        = seq_ff;
      req_stall     = (seq_ff != SEQ_IDLE);
      ram_raddr     = '0;
      trk_start_in  = trk_start_ff;
      trk_next_in   = trk_next_ff;
      walk_k_in     = walk_k_ff;
      pend_in       = 1'b0;
      hit_start_in  = hit_start_ff;
      hit_trk_in    = hit_trk_ff;
      hit_ctrl_in   = hit_ctrl_ff;
      rsp_load      = 1'b0;
      st            = ram_rdata[27:8];
      case (seq_ff)
         SEQ_IDLE: begin
            if (req_xfer) seq_in = SEQ_LOOK_A;
         end
         SEQ_LOOK_A: begin
            ram_raddr = TocAddrW'(trk_idx);
            seq_in    = SEQ_LOOK_B;
         end
         SEQ_LOOK_B: begin
            trk_start_in = toc_valid_ff ? st : 20'd0;
            ram_raddr    = TocAddrW'(trk2_idx);
            seq_in       = SEQ_LOOK_C;
         end
         SEQ_LOOK_C: begin
            if (trk2 >= ntracks) begin
               trk_next_in = leadout_eff;
            end else begin
               trk_next_in = toc_valid_ff ? st : 20'd0;
            end
            seq_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            walk_k_in    = 7'd0;
            hit_start_in = 20'd0;
            hit_trk_in   = 7'd0;
            hit_ctrl_in  = NO_TOC_CONTROL;
            seq_in       = SEQ_WALK;
         end
         SEQ_WALK: begin
            if (pend_ff && st <= cur_ff) begin
               hit_start_in = st;
               hit_trk_in   = pend_k_ff;
               hit_ctrl_in  = ram_rdata[7:0];
            end
            if (walk_issue) begin
               ram_raddr = TocAddrW'(walk_k_ff);
               walk_k_in = walk_k_ff + 7'd1;
               pend_in   = 1'b1;
            end else if (!pend_ff) begin
               seq_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               seq_in   = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         play_ff      <= PLAY_IDLE;
         cur_ff       <= 20'd0;
         fetch_ff     <= 20'd0;
         stop_ff      <= 20'd0;
         scan_ff      <= 1'b0;
         rev_ff       <= 1'b0;
         flush_ff     <= 8'd0;
      end else begin
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (seq_ff == SEQ_EXEC) begin
            play_ff  <= play_in;
            cur_ff   <= cur_in;
            fetch_ff <= fetch_in;
            stop_ff  <= stop_in;
            scan_ff  <= scan_in;
            rev_ff   <= rev_in;
            flush_ff <= flush_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         oper_ff   <= req_operation;
         opc_ff    <= req_cmd_opcode;
         flags_ff  <= req_cmd_flags;
         mid_ff    <= req_cmd_bytes_mid;
         tail_ff   <= req_cmd_bytes_tail;
         tidx_ff   <= req_toc_index;
         tstart_ff <= req_toc_start_lba;
         tctrl_ff  <= req_toc_control;
      end
      if (seq_ff == SEQ_EXEC) begin
         fv_ff   <= fv_in;
         flba_ff <= flba_in;
      end
      trk_start_ff <= trk_start_in;
      trk_next_ff  <= trk_next_in;
      walk_k_ff    <= walk_k_in;
      pend_k_ff    <= walk_k_ff;
      hit_start_ff <= hit_start_in;
      hit_trk_ff   <= hit_trk_in;
      hit_ctrl_ff  <= hit_ctrl_in;
      if (rsp_load) begin
         o_fv_ff     <= fv_ff;
         o_flba_ff   <= flba_ff;
         o_status_ff <= play_ff;
         o_trk_ff    <= hit_trk_ff + 7'd1;
         o_ctrl_ff   <= hit_ctrl_ff;
         o_abs_ff    <= cur_ff;
         o_rel_ff    <= cur_ff - hit_start_ff;
         o_flush_ff  <= flush_ff;
      end
   end

   cdap_ram #(
      .WIDTH (TocDataW),
      .DEPTH (MaxTracks)
   ) u_toc_ram (
      .clock (clock),
      .we    (ram_we & (seq_ff == SEQ_EXEC)),
      .waddr (TocAddrW'(tidx_ff)),
      .wdata ({tstart_ff, tctrl_ff}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_valid   = o_fv_ff;
   assign rsp_frame_lba     = o_flba_ff;
   assign rsp_audio_status  = o_status_ff;
   assign rsp_track_number  = o_trk_ff;
   assign rsp_track_control = o_ctrl_ff;
   assign rsp_abs_lba       = o_abs_ff;
   assign rsp_rel_lba       = o_rel_ff;
   assign rsp_flush_count   = o_flush_ff;

endmodule

>>> design/cdap_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/cdap_checker.sv
// Port-level checker for the audio play controller and its bind.
`include "cd_audio_play_controller_assert.svh"

module cdap_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_frame_valid,
   input logic [19:0] rsp_frame_lba
);

   // A held result stays on offer until its transfer.
   `CDAP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   // The block works on one item at a time, so it stalls right after a transfer in.
   `CDAP_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
   // A result without a sector reports a zero sector address.
   `CDAP_ASSERT_SAME(a_no_frame_zero, rsp_valid && !rsp_frame_valid, rsp_frame_lba == 20'd0)

endmodule

bind cd_audio_play_controller cdap_checker u_cdap_checker (.*);
